@@ rtl/erp_pkg.sv @@
// Shared types and constants for the escape reply parser.
package erp_pkg;

    // Parser states.
    typedef enum logic [2:0] {
        PS_IDLE     = 3'd0,
        PS_ESC      = 3'd1,
        PS_BODY     = 3'd2,
        PS_BODY_ESC = 3'd3,
        PS_CSI      = 3'd4
    } parse_state_t;

    // Emission sequencer states.
    typedef enum logic [1:0] {
        EM_PARSE  = 2'd0,
        EM_READ   = 2'd1,
        EM_LOAD   = 2'd2,
        EM_STATUS = 2'd3
    } emit_state_t;

    // Input item kinds.
    localparam logic OP_BYTE     = 1'b0;
    localparam logic OP_DEADLINE = 1'b1;

    // Result item kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Status codes.
    localparam logic [1:0] STAT_NONE     = 2'd0;
    localparam logic [1:0] STAT_CAPTURED = 2'd1;
    localparam logic [1:0] STAT_ILLEGAL  = 2'd2;
    localparam logic [1:0] STAT_TOO_LONG = 2'd3;

    // Character codes.
    localparam logic [7:0] C_ESC       = 8'h1b;
    localparam logic [7:0] C_BEL       = 8'h07;
    localparam logic [7:0] C_CTRL_TOP  = 8'h20;
    localparam logic [7:0] C_FINAL_LO  = 8'h40;
    localparam logic [7:0] C_FINAL_HI  = 8'h7e;
    localparam logic [7:0] C_CPR_FINAL = 8'h52;
    localparam logic [7:0] C_RBRACKET  = 8'h5d;
    localparam logic [7:0] C_LBRACKET  = 8'h5b;
    localparam logic [7:0] C_BSLASH    = 8'h5c;

    // End-of-reply request from the parser to the emission sequencer.
    typedef struct packed {
        logic       valid;
        logic       captured;
        logic [1:0] status;
    } finish_t;

endpackage

@@ rtl/erp_parser.sv @@
// Byte-level escape sequence parser that fills the body store and flags reply ends.
module erp_parser #(
    parameter int BUF_DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  logic                         in_op,
    input  logic [7:0]                   in_byte,
    output logic                         wr_en,
    output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
    output logic [7:0]                   wr_data,
    output erp_pkg::finish_t             finish,
    output logic [$clog2(BUF_DEPTH)-1:0] count
);

    localparam int CNT_W = $clog2(BUF_DEPTH);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUF_DEPTH - 1);

    erp_pkg::parse_state_t state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  cap_reg, cap_next;

    // State, count and captured flag registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= erp_pkg::PS_IDLE;
            cnt_reg   <= '0;
            cap_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            cap_reg   <= cap_next;
        end
    end

    assign wr_addr = cnt_reg;
    assign wr_data = in_byte;
    assign count   = cnt_reg;

    // Next-state decode for one accepted item.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cap_next   = cap_reg;
        wr_en      = 1'b0;
        finish     = '0;

        if (in_valid) begin
            if (in_op == erp_pkg::OP_DEADLINE) begin
                finish.valid    = 1'b1;
                finish.captured = cap_reg;
                finish.status   = cap_reg ? erp_pkg::STAT_CAPTURED : erp_pkg::STAT_NONE;
            end else begin
                case (state_reg)
                    erp_pkg::PS_ESC: begin
                        if (in_byte < erp_pkg::C_CTRL_TOP) begin
                            finish.valid  = 1'b1;
                            finish.status = erp_pkg::STAT_ILLEGAL;
                        end else if (in_byte == erp_pkg::C_RBRACKET) begin
                            state_next = erp_pkg::PS_BODY;
                            cnt_next   = '0;
                        end else if (in_byte == erp_pkg::C_LBRACKET) begin
                            state_next = erp_pkg::PS_CSI;
                        end else begin
                            state_next = erp_pkg::PS_IDLE;
                        end
                    end
                    erp_pkg::PS_BODY: begin
                        if (in_byte == erp_pkg::C_BEL) begin
                            cap_next   = 1'b1;
                            state_next = erp_pkg::PS_IDLE;
                        end else if (in_byte == erp_pkg::C_ESC) begin
                            state_next = erp_pkg::PS_BODY_ESC;
                        end else if (cnt_reg != CNT_MAX) begin
                            wr_en    = 1'b1;
                            cnt_next = cnt_reg + 1'b1;
                        end else begin
                            finish.valid  = 1'b1;
                            finish.status = erp_pkg::STAT_TOO_LONG;
                        end
                    end
                    erp_pkg::PS_BODY_ESC: begin
                        if (in_byte < erp_pkg::C_CTRL_TOP) begin
                            finish.valid  = 1'b1;
                            finish.status = erp_pkg::STAT_ILLEGAL;
                        end else if (in_byte == erp_pkg::C_BSLASH) begin
                            cap_next   = 1'b1;
                            state_next = erp_pkg::PS_IDLE;
                        end else begin
                            // A new sequence inside the body drops what was stored.
                            cnt_next = '0;
                            if (in_byte == erp_pkg::C_RBRACKET) begin
                                state_next = erp_pkg::PS_BODY;
                            end else if (in_byte == erp_pkg::C_LBRACKET) begin
                                state_next = erp_pkg::PS_CSI;
                            end else begin
                                state_next = erp_pkg::PS_IDLE;
                            end
                        end
                    end
                    erp_pkg::PS_CSI: begin
                        if (in_byte inside {[erp_pkg::C_FINAL_LO:erp_pkg::C_FINAL_HI]}) begin
                            if (in_byte == erp_pkg::C_CPR_FINAL) begin
                                finish.valid    = 1'b1;
                                finish.captured = cap_reg;
                                finish.status   = cap_reg ? erp_pkg::STAT_CAPTURED
                                                          : erp_pkg::STAT_NONE;
                            end else begin
                                state_next = erp_pkg::PS_IDLE;
                            end
                        end
                    end
                    default: begin
                        state_next = (in_byte == erp_pkg::C_ESC) ? erp_pkg::PS_ESC
                                                                 : erp_pkg::PS_IDLE;
                    end
                endcase
            end

            // Any reply end returns the parser to its reset state.
            if (finish.valid) begin
                state_next = erp_pkg::PS_IDLE;
                cnt_next   = '0;
                cap_next   = 1'b0;
            end
        end
    end

endmodule

@@ rtl/escape_reply_parser.sv @@
// Top level: parser, body store memory and reply emission sequencer.
//
//  Channel  Dir  Handshake          Contents
//  s_       in   s_tvalid/s_tready  tdata = in_byte, tuser = op
//  m_       out  m_tvalid/m_tready  tdata = out_byte, status; tuser = item_kind; tlast = last
//
// s_tready is high whenever no reply is being emitted. Emitting a captured reply
// reads each stored body byte from memory, then loads it into the output register,
// and ends with the status item; m_tready stalls can hold the loads.
// While a reply is emitted no item is accepted. The store needs no clearing after
// reset; only bytes written during the current body are ever read back.
module escape_reply_parser #(
    parameter int BUF_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status, [15:10] zero
    output logic        m_tuser,   // [0] item_kind
    output logic        m_tlast
);

    localparam int CNT_W = $clog2(BUF_DEPTH);

    erp_pkg::emit_state_t mode_reg, mode_next;
    erp_pkg::finish_t     finish;

    logic                 s_accept;
    logic                 wr_en;
    logic [CNT_W-1:0]     wr_addr;
    logic [7:0]           wr_data;
    logic [CNT_W-1:0]     count;

    logic [7:0]           mem [BUF_DEPTH];
    logic [7:0]           mem_rdata_reg;

    logic [CNT_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]     emit_cnt_reg, emit_cnt_next;
    logic [1:0]           stat_reg, stat_next;

    logic                 out_free;
    logic                 load_payload;
    logic                 load_status;
    logic                 m_valid_reg;
    logic [7:0]           m_byte_reg;
    logic [1:0]           m_stat_reg;
    logic                 m_kind_reg;

    assign s_tready = (mode_reg == erp_pkg::EM_PARSE);
    assign s_accept = s_tvalid && s_tready;

    erp_parser #(
        .BUF_DEPTH(BUF_DEPTH)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(s_accept),
        .in_op   (s_tuser),
        .in_byte (s_tdata),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .finish  (finish),
        .count   (count)
    );

    // Body store: writes only while parsing; the registered read runs always but is used only while emitting.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        mem_rdata_reg <= mem[rd_idx_reg];
    end

    assign out_free = !m_valid_reg || m_tready;

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= erp_pkg::EM_PARSE;
        end else begin
            mode_reg <= mode_next;
        end
        rd_idx_reg   <= rd_idx_next;
        emit_cnt_reg <= emit_cnt_next;
        stat_reg     <= stat_next;
    end

    // Sequencer next state: walk the stored body of a captured reply, then send the status item.
    always_comb begin
        mode_next     = mode_reg;
        rd_idx_next   = rd_idx_reg;
        emit_cnt_next = emit_cnt_reg;
        stat_next     = stat_reg;
        load_payload  = 1'b0;
        load_status   = 1'b0;

        case (mode_reg)
            erp_pkg::EM_PARSE: begin
                if (finish.valid) begin
                    emit_cnt_next = count;
                    stat_next     = finish.status;
                    rd_idx_next   = '0;
                    mode_next     = (finish.captured && count != '0) ? erp_pkg::EM_READ
                                                                     : erp_pkg::EM_STATUS;
                end
            end
            erp_pkg::EM_READ: begin
                mode_next = erp_pkg::EM_LOAD;
            end
            erp_pkg::EM_LOAD: begin
                if (out_free) begin
                    load_payload = 1'b1;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    mode_next    = (rd_idx_next == emit_cnt_reg) ? erp_pkg::EM_STATUS
                                                                 : erp_pkg::EM_READ;
                end
            end
            erp_pkg::EM_STATUS: begin
                if (out_free) begin
                    load_status = 1'b1;
                    mode_next   = erp_pkg::EM_PARSE;
                end
            end
            default: begin
                mode_next = erp_pkg::EM_PARSE;
            end
        endcase
    end

    // Output register; a waiting status item does not block parsing of later bytes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_payload || load_status) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
        if (load_payload) begin
            m_byte_reg <= mem_rdata_reg;
            m_stat_reg <= erp_pkg::STAT_NONE;
            m_kind_reg <= erp_pkg::KIND_PAYLOAD;
        end else if (load_status) begin
            m_byte_reg <= 8'h00;
            m_stat_reg <= stat_reg;
            m_kind_reg <= erp_pkg::KIND_STATUS;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_stat_reg, m_byte_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = (m_kind_reg == erp_pkg::KIND_STATUS);

`ifndef SYNTHESIS
    // The store is never written while a reply is read back.
    a_no_write_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (mode_reg == erp_pkg::EM_PARSE))
        else $error("body store written during reply emission");

    // Reads stay below the number of bytes held for this reply.
    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (mode_reg == erp_pkg::EM_READ) |-> (rd_idx_reg < emit_cnt_reg))
        else $error("body store read beyond held bytes");

    // A payload item carries no status code.
    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == erp_pkg::KIND_PAYLOAD) |-> (m_tdata[9:8] == erp_pkg::STAT_NONE))
        else $error("payload item with nonzero status");

    // The status item closes the emission and reopens the input.
    a_status_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        load_status |=> s_tready)
        else $error("input not reopened after status item");
`endif

endmodule
